/* rtl/core/plq_pkg.sv */
`default_nettype none

package plq_pkg;

	// Queue geometry.
	localparam int SLOTS   = 256;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int COUNT_W = $clog2(SLOTS + 1);

	// Volume widths: one order, the whole level, one accumulator cell.
	localparam int VOL_W     = 32;
	localparam int LVL_W     = 40;
	localparam int CELL_W    = 8;
	localparam int VOL_CELLS = LVL_W / CELL_W;

	// Command codes.
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_ERASE = 2'd2;

	// Stream widths.
	localparam int IN_DATA_W  = 40;
	localparam int OUT_BITS   = 8 + VOL_W + COUNT_W + LVL_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

/* rtl/core/plq_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module plq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/plq_vol_cell.sv */
`default_nettype none

// One byte of the running level volume. The cell adds or subtracts its byte
// of the operand, takes the carry from the cell below and hands its own
// carry to the cell above.
module plq_vol_cell
	import plq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              sub,
	input  wire logic [CELL_W-1:0] operand,
	input  wire logic              carry_in,
	output logic                   carry_out,
	output logic      [CELL_W-1:0] level_next
);

	logic [CELL_W-1:0] level_q;
	logic [CELL_W-1:0] op_eff;
	logic [CELL_W:0]   sum;

	assign op_eff     = sub ? ~operand : operand;
	assign sum        = {1'b0, level_q} + {1'b0, op_eff} + {{CELL_W{1'b0}}, carry_in};
	assign carry_out  = sum[CELL_W];
	assign level_next = en ? sum[CELL_W-1:0] : level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (en) begin
			level_q <= sum[CELL_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/price_level_order_queue.sv */
// A word accepted at a clock edge has its result loaded into the output
// register at the next edge; every command takes the same path.
// A new word is taken only after exec is over, as the read of the link and volume
// memories is followed by the write of the neighbor links in exec.
// Reset (arst_n, asynchronous, active low) empties the level and clears control
// state; the link and volume memories are not cleared and need no clearing pass.
`default_nettype none

module price_level_order_queue
	import plq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Command stream.
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// From bit 0: order_slot[7:0], order_volume[31:0].
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// From bit 0: command[1:0].
	input  wire logic [1:0]            s_axis_tuser,
	// Result stream.
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// From bit 0: popped_slot[7:0], popped_volume[31:0], count_now[8:0],
	// volume_now[39:0], zero fill.
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	// From bit 0: was_empty.
	output logic                       m_axis_tuser
);

	// The sequencer has two states. In idle it waits for a command word and
	// starts the memory reads; in exec the read data is back, the links are
	// rewritten and the result word is loaded.
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic               state_q;
	logic [1:0]         cmd_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [VOL_W-1:0]   vol_q;
	logic [SLOT_W-1:0]  head_q;
	logic [SLOT_W-1:0]  tail_q;
	logic [COUNT_W-1:0] count_q;

	logic               out_valid_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [VOL_W-1:0]   out_vol_q;
	logic               out_empty_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [LVL_W-1:0]   out_level_q;

	logic               accept;
	logic               exec;
	logic [SLOT_W-1:0]  in_slot;
	logic [VOL_W-1:0]   in_vol;
	logic [SLOT_W-1:0]  rd_addr;

	logic [SLOT_W-1:0]  next_rd;
	logic [SLOT_W-1:0]  prev_rd;
	logic [VOL_W-1:0]   vol_rd;

	logic               is_push;
	logic               is_pop;
	logic               is_rm;
	logic               lvl_empty;
	logic               lvl_full;
	logic               single;
	logic               do_push;
	logic               do_rm;
	logic [SLOT_W-1:0]  victim;
	logic               rm_head;
	logic               rm_tail;
	logic               rm_mid;
	logic [COUNT_W-1:0] count_d;

	logic               next_we;
	logic [SLOT_W-1:0]  next_wa;
	logic [SLOT_W-1:0]  next_wd;
	logic               prev_we;
	logic [SLOT_W-1:0]  prev_wa;
	logic [SLOT_W-1:0]  prev_wd;

	logic               vol_en;
	logic               vol_sub;
	logic [LVL_W-1:0]   vol_operand;
	logic [VOL_CELLS:0] carry;
	logic [LVL_W-1:0]   level_d;

	// A new word is taken in idle whenever the output register is free or is
	// being emptied in the same cycle.
	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign exec          = (state_q == ST_EXEC);
	assign in_slot       = s_axis_tdata[SLOT_W-1:0];
	assign in_vol        = s_axis_tdata[8 +: VOL_W];

	// Pop reads the entry of the current head, erase and push that of the
	// named slot. All three memories share the read address.
	assign rd_addr = (s_axis_tuser == CMD_POP) ? head_q : in_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_axis_tuser;
			slot_q <= in_slot;
			vol_q  <= in_vol;
		end
	end

	// Decode of the command held in exec.
	assign is_push   = (cmd_q == CMD_PUSH);
	assign is_pop    = (cmd_q == CMD_POP);
	assign is_rm     = is_pop || (cmd_q == CMD_ERASE);
	assign lvl_empty = (count_q == '0);
	assign lvl_full  = (count_q == COUNT_W'(SLOTS));
	assign single    = (count_q == COUNT_W'(1));
	assign do_push   = exec && is_push && !lvl_full;
	assign do_rm     = exec && is_rm && !lvl_empty;
	assign victim    = is_pop ? head_q : slot_q;

	// With a single order left the level simply empties. Otherwise the victim
	// is the head, the tail, or sits in the middle, where its two neighbors
	// are linked to each other.
	assign rm_head = do_rm && !single && (victim == head_q);
	assign rm_tail = do_rm && !single && (victim != head_q) && (victim == tail_q);
	assign rm_mid  = do_rm && !single && (victim != head_q) && (victim != tail_q);

	always_comb begin
		next_we = 1'b0;
		next_wa = tail_q;
		next_wd = slot_q;
		prev_we = 1'b0;
		prev_wa = slot_q;
		prev_wd = tail_q;
		if (do_push && !lvl_empty) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end else if (rm_mid) begin
			next_we = 1'b1;
			next_wa = prev_rd;
			next_wd = next_rd;
			prev_we = 1'b1;
			prev_wa = next_rd;
			prev_wd = prev_rd;
		end
	end

	plq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
		.clk     (clk),
		.wr_en   (next_we),
		.wr_addr (next_wa),
		.wr_data (next_wd),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (next_rd)
	);

	plq_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_prev_ram (
		.clk     (clk),
		.wr_en   (prev_we),
		.wr_addr (prev_wa),
		.wr_data (prev_wd),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (prev_rd)
	);

	plq_ram #(.WIDTH(VOL_W), .DEPTH(SLOTS)) u_vol_ram (
		.clk     (clk),
		.wr_en   (do_push),
		.wr_addr (slot_q),
		.wr_data (vol_q),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (vol_rd)
	);

	// Head, tail and order count.
	always_comb begin
		count_d = count_q;
		if (do_push) begin
			count_d = count_q + COUNT_W'(1);
		end else if (do_rm) begin
			count_d = count_q - COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (do_push) begin
				if (lvl_empty) begin
					head_q <= slot_q;
				end
				tail_q <= slot_q;
			end else if (do_rm && single) begin
				head_q <= '0;
				tail_q <= '0;
			end else if (rm_head) begin
				head_q <= next_rd;
			end else if (rm_tail) begin
				tail_q <= prev_rd;
			end
		end
	end

	// The level volume lives in a row of byte cells. A push adds the new
	// order's volume; a removal adds the inverted stored volume with a carry
	// into the lowest cell, which subtracts modulo 2^40.
	assign vol_en      = do_push || do_rm;
	assign vol_sub     = do_rm;
	assign vol_operand = do_rm ? {{(LVL_W - VOL_W){1'b0}}, vol_rd}
	                           : {{(LVL_W - VOL_W){1'b0}}, vol_q};
	assign carry[0]    = vol_sub;

	for (genvar i = 0; i < VOL_CELLS; i++) begin : g_vol_cell
		plq_vol_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (vol_en),
			.sub        (vol_sub),
			.operand    (vol_operand[i*CELL_W +: CELL_W]),
			.carry_in   (carry[i]),
			.carry_out  (carry[i+1]),
			.level_next (level_d[i*CELL_W +: CELL_W])
		);
	end

	// Output register. It is loaded at the end of exec and holds until the
	// word is taken; the input side may take the next command in the cycle the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_slot_q  <= (is_pop && !lvl_empty) ? head_q : '0;
			out_vol_q   <= (is_pop && !lvl_empty) ? vol_rd : '0;
			out_empty_q <= is_rm && lvl_empty;
			out_count_q <= count_d;
			out_level_q <= level_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_empty_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}},
	                        out_level_q, out_count_q, out_vol_q, out_slot_q};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(SLOTS))
		else $error("order count exceeds the number of slots");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0) && (tail_q == '0))
		else $error("empty level with nonzero head or tail");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted command did not enter exec");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (state_q == ST_IDLE))
		else $error("ready raised outside idle");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_EXEC))
		else $error("result word appeared without an exec cycle");
`endif

endmodule

`default_nettype wire
